// ----- design/lkv_pkg.sv -----
// shared types and constants for the lru key-value cache
`default_nettype none
package lkv_pkg;

  localparam int DEPTH   = 16;
  localparam int AGE_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CAP_W   = 5;
  localparam int CMP_W   = (CAP_W > CNT_W) ? CAP_W : CNT_W;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  typedef struct packed {
    logic                    kind;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;
  } rsp_t;

  // what one transaction does to the slot store
  typedef struct packed {
    logic             found;
    logic [DEPTH-1:0] hit_sel;
    logic [DEPTH-1:0] tgt;
    logic             update;
    logic             write;
    logic             admit;
    logic [CNT_W-1:0] thresh;
  } plan_t;

endpackage
`default_nettype wire

// ----- design/lkv_plan.sv -----
// lookup, free slot and victim selection for one transaction
`default_nettype none
module lkv_plan (
  input  wire logic                                     req_kind,
  input  wire logic [lkv_pkg::KEY_W-1:0]                req_key,
  input  wire logic [lkv_pkg::DEPTH-1:0]                slot_valid,
  input  wire logic [lkv_pkg::DEPTH-1:0][lkv_pkg::KEY_W-1:0] slot_key,
  input  wire logic [lkv_pkg::DEPTH-1:0][lkv_pkg::AGE_W-1:0] slot_age,
  input  wire logic [lkv_pkg::CNT_W-1:0]                used,
  input  wire logic [lkv_pkg::CNT_W-1:0]                eff_cap,
  output lkv_pkg::plan_t                                plan
);
  import lkv_pkg::*;

  logic [DEPTH-1:0] match;
  logic [DEPTH-1:0] empty;
  logic [DEPTH-1:0] free_sel;
  logic [DEPTH-1:0] victim;
  logic [AGE_W-1:0] hit_age;
  logic [CNT_W-1:0] used_m1;
  logic             fill;

  assign used_m1  = used - CNT_W'(1);
  assign empty    = ~slot_valid;
  assign free_sel = empty & (~empty + DEPTH'(1));
  assign fill     = (used < eff_cap) && (|empty);

  always_comb begin
    hit_age = '0;
    for (int i = 0; i < DEPTH; i++) begin
      match[i]  = slot_valid[i] && (slot_key[i] == req_key);
      // ages of valid slots are a permutation of 0..used-1
      victim[i] = slot_valid[i] && (slot_age[i] == used_m1[AGE_W-1:0]);
      if (match[i]) begin
        hit_age = hit_age | slot_age[i];
      end
    end
  end

  always_comb begin
    plan.found   = |match;
    plan.hit_sel = match;
    plan.write   = (req_kind == KIND_PUT);
    plan.update  = plan.found || plan.write;
    plan.admit   = plan.write && !plan.found && fill;
    if (plan.found) begin
      plan.tgt    = match;
      plan.thresh = CNT_W'(hit_age);
    end else if (fill) begin
      plan.tgt    = free_sel;
      plan.thresh = used;
    end else begin
      plan.tgt    = victim;
      plan.thresh = used_m1;
    end
  end

endmodule
`default_nettype wire

// ----- design/lru_key_value_cache.sv -----
// top level of the fully associative lru key-value cache
`default_nettype none
// Fully associative key-value cache of lkv_pkg::DEPTH slots with
// least-recently-used replacement. A transaction (get or put) is taken
// at a clock edge with start high and busy low; one may be taken every
// cycle. Each transaction gives exactly one result, on out_rsp with
// out_valid high for one cycle, from the result register behind the
// request register, in order. The receiver cannot hold results off.
// The work for one transaction lies between the request register and
// the result register: a parallel key compare over all slot registers
// plus the age update, so the throughput is one transaction per cycle.
// busy is high only while reset is applied and in the cycle after.
// Capacity is written through cfg_we/cfg_wdata while the cache is idle;
// zero acts as one, values above DEPTH act as DEPTH. Lowering it never
// drops entries, later put misses simply evict.
module lru_key_value_cache (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire lkv_pkg::req_t              in_req,
  output logic                            out_valid,
  output lkv_pkg::rsp_t                   out_rsp,
  input  wire logic                       cfg_we,
  input  wire logic [lkv_pkg::CAP_W-1:0]  cfg_wdata
);
  import lkv_pkg::*;

  // control
  logic             busy_r;
  logic             req_vld_r;
  logic             out_valid_r;
  logic [CAP_W-1:0] cap_r;
  logic [CNT_W-1:0] used_r;
  logic [CNT_W-1:0] used_nxt;
  logic [CNT_W-1:0] eff_cap;
  logic             accept;

  // request and result registers
  req_t req_r;
  rsp_t rsp_r;
  rsp_t rsp_nxt;

  // slot store
  logic [DEPTH-1:0]            slot_valid_r;
  logic [DEPTH-1:0][KEY_W-1:0] slot_key_r;
  logic [DEPTH-1:0][VAL_W-1:0] slot_value_r;
  logic [DEPTH-1:0][AGE_W-1:0] slot_age_r;

  plan_t            plan;
  logic [VAL_W-1:0] hit_value;

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_rsp   = rsp_r;

  // clamp capacity to 1..DEPTH
  always_comb begin
    if (CMP_W'(cap_r) == CMP_W'(0)) begin
      eff_cap = CNT_W'(1);
    end else if (CMP_W'(cap_r) > CMP_W'(DEPTH)) begin
      eff_cap = CNT_W'(DEPTH);
    end else begin
      eff_cap = CNT_W'(cap_r);
    end
  end

  lkv_plan u_plan (
    .req_kind   (req_r.kind),
    .req_key    (req_r.key),
    .slot_valid (slot_valid_r),
    .slot_key   (slot_key_r),
    .slot_age   (slot_age_r),
    .used       (used_r),
    .eff_cap    (eff_cap),
    .plan       (plan)
  );

  // stored value of the matching slot, at most one matches
  always_comb begin
    hit_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (plan.hit_sel[i]) begin
        hit_value = hit_value | slot_value_r[i];
      end
    end
  end

  always_comb begin
    rsp_nxt.hit = plan.found;
    if (req_r.kind == KIND_PUT) begin
      rsp_nxt.read_value = '0;
    end else if (plan.found) begin
      rsp_nxt.read_value = hit_value;
    end else begin
      rsp_nxt.read_value = MISS_VALUE;
    end
  end

  assign used_nxt = (req_vld_r && plan.admit) ? used_r + CNT_W'(1) : used_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      req_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      cap_r       <= CAP_RESET;
      used_r      <= '0;
    end else begin
      busy_r      <= 1'b0;
      req_vld_r   <= accept;
      out_valid_r <= req_vld_r;
      used_r      <= used_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req;
    end
    if (req_vld_r) begin
      rsp_r <= rsp_nxt;
    end
  end

  // valid bits and ages, the target becomes most recent
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      slot_age_r   <= '0;
    end else if (req_vld_r && plan.update) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (plan.tgt[i]) begin
          slot_age_r[i] <= '0;
          if (plan.admit) begin
            slot_valid_r[i] <= 1'b1;
          end
        end else if (slot_valid_r[i] && (CNT_W'(slot_age_r[i]) < plan.thresh)) begin
          slot_age_r[i] <= slot_age_r[i] + AGE_W'(1);
        end
      end
    end
  end

  // keys and values, no reset
  always_ff @(posedge clk) begin
    if (req_vld_r && plan.write) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (plan.tgt[i]) begin
          slot_key_r[i]   <= req_r.key;
          slot_value_r[i] <= req_r.value;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(DEPTH))
    else $error("used count above depth");

  a_used_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(slot_valid_r) == int'(used_r))
    else $error("used count differs from valid slots");

  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    req_vld_r |-> $onehot0(plan.hit_sel))
    else $error("key present in more than one slot");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    req_vld_r |=> out_valid)
    else $error("transaction produced no result");

  a_put_target: assert property (@(posedge clk) disable iff (!rst_n)
    (req_vld_r && plan.write) |-> $onehot(plan.tgt))
    else $error("put without a single target slot");
`endif

endmodule
`default_nettype wire

// ----- test/lkv_checker.sv -----
// checker for the lru key-value cache: predicts every result and compares it
`timescale 1ns / 1ps
module lkv_checker (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic                      busy,
  input  wire lkv_pkg::req_t             in_req,
  input  wire logic                      out_valid,
  input  wire lkv_pkg::rsp_t             out_rsp,
  input  wire logic                      cfg_we,
  input  wire logic [lkv_pkg::CAP_W-1:0] cfg_wdata,
  output int                             fail_count,
  output int                             pending,
  output int                             checked,
  output int                             hits
);
  import lkv_pkg::*;

  // shadow copy of the slot store
  logic [CAP_W-1:0] capacity;
  logic             occ        [DEPTH];
  logic [KEY_W-1:0] stored_key [DEPTH];
  logic [VAL_W-1:0] stored_val [DEPTH];
  logic [AGE_W-1:0] recency    [DEPTH];
  int               fill_count;
  rsp_t             rsp_expected [$];
  rsp_t             want;
  rsp_t             fresh;

  function automatic int cap_in_force();
    if (capacity == '0) return 1;
    if (int'(capacity) > DEPTH) return DEPTH;
    return int'(capacity);
  endfunction

  // slot s becomes most recent, younger valid slots age by one
  task automatic promote(input int s);
    logic [AGE_W-1:0] a;
    a = recency[s];
    for (int i = 0; i < DEPTH; i++)
      if (i != s && occ[i] && recency[i] < a) recency[i] = recency[i] + 1'b1;
    recency[s] = '0;
  endtask

  task automatic cache_access(input req_t r, output rsp_t p);
    int found;
    int target;
    int oldest;
    found  = -1;
    target = -1;
    oldest = -1;
    for (int i = 0; i < DEPTH; i++)
      if (found < 0 && occ[i] && stored_key[i] == r.key) found = i;
    p.hit        = (found >= 0);
    p.read_value = '0;
    if (r.kind == KIND_GET) begin
      if (found >= 0) begin
        promote(found);
        p.read_value = stored_val[found];
      end else begin
        p.read_value = MISS_VALUE;
      end
    end else if (found >= 0) begin
      stored_val[found] = r.value;
      promote(found);
    end else begin
      if (fill_count < cap_in_force())
        for (int i = 0; i < DEPTH; i++)
          if (target < 0 && !occ[i]) target = i;
      if (target >= 0) begin
        // new entry: every other valid slot ages
        for (int i = 0; i < DEPTH; i++)
          if (i != target && occ[i]) recency[i] = recency[i] + 1'b1;
        occ[target]        = 1'b1;
        recency[target]    = '0;
        stored_key[target] = r.key;
        stored_val[target] = r.value;
        fill_count++;
      end else begin
        for (int i = 0; i < DEPTH; i++)
          if (occ[i] && (oldest < 0 || recency[i] > recency[oldest])) oldest = i;
        if (oldest >= 0) begin
          stored_key[oldest] = r.key;
          stored_val[oldest] = r.value;
          promote(oldest);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      capacity   = CAP_RESET;
      fill_count = 0;
      for (int i = 0; i < DEPTH; i++) begin
        occ[i]     = 1'b0;
        recency[i] = '0;
      end
      rsp_expected.delete();
      fail_count = 0;
      pending    = 0;
      checked    = 0;
      hits       = 0;
    end else begin
      if (cfg_we) capacity = cfg_wdata;
      if (out_valid) begin
        if (rsp_expected.size() == 0) begin
          fail_count++;
          $display("%0t: result with nothing expected, actual hit %0b read_value %h",
                   $time, out_rsp.hit, out_rsp.read_value);
        end else begin
          want = rsp_expected.pop_front();
          checked++;
          if (want.hit) hits++;
          if (out_rsp.hit !== want.hit) begin
            fail_count++;
            $display("%0t: hit mismatch, expected %0b actual %0b",
                     $time, want.hit, out_rsp.hit);
          end
          if (out_rsp.read_value !== want.read_value) begin
            fail_count++;
            $display("%0t: read_value mismatch, expected %h actual %h",
                     $time, want.read_value, out_rsp.read_value);
          end
        end
      end
      if (start && !busy) begin
        cache_access(in_req, fresh);
        rsp_expected.push_back(fresh);
      end
      pending = rsp_expected.size();
    end
  end

endmodule

// ----- test/tb.sv -----
// testbench top for the lru key-value cache: stimulus, capacity phases and verdict
`timescale 1ns / 1ps
module tb;
  import lkv_pkg::*;

  // watchdog limit, with a wide margin over the slowest run
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 112;
  localparam int POOL_MAX    = 32;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             start;
  logic             busy;
  req_t             in_req;
  logic             out_valid;
  rsp_t             out_rsp;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  int fail_count;
  int pending;
  int checked;
  int hits;
  int cycles = 0;
  int sent   = 0;
  int phases = 0;
  int burst_left = 1;

  // keys that random transactions mostly draw from, so hits and evictions happen
  logic [KEY_W-1:0] key_pool [POOL_MAX];
  int               pool_n;

  lru_key_value_cache u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // watches both channels and the capacity port, predicts and compares
  lkv_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_rsp    (out_rsp),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .hits       (hits)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog: a hung handshake or a lost result ends here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic req_t txn(input logic kind, input logic [KEY_W-1:0] k,
                               input logic [VAL_W-1:0] v);
    req_t r;
    r.kind  = kind;
    r.key   = k;
    r.value = v;
    return r;
  endfunction

  // values lean towards the extremes now and then
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '1;
      3:       return '0;
      default: return $urandom();
    endcase
  endfunction

  // mostly pool puts and gets, the rest stray keys that nearly always miss
  function automatic req_t make_item();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45)
      return txn(KIND_PUT, key_pool[$urandom_range(0, pool_n - 1)], pick_word());
    if (sel < 85)
      return txn(KIND_GET, key_pool[$urandom_range(0, pool_n - 1)], pick_word());
    return txn(($urandom_range(0, 1) == 1) ? KIND_PUT : KIND_GET, pick_word(), pick_word());
  endfunction

  // start stays high until the transaction is taken; busy is read before the edge's updates
  task automatic send_txn(input req_t r);
    start  <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  // bursts of random length, random gaps in between, junk on the bus while idle
  task automatic pace_sender();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        start  <= 1'b0;
        in_req <= make_item();
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic put_get(input req_t r);
    send_txn(r);
    pace_sender();
  endtask

  // stop sending, wait for every result, then let the pipeline settle
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(input logic [CAP_W-1:0] cap);
    int lim;
    write_capacity(cap);
    phases++;
    lim = (cap == '0) ? 1 : ((int'(cap) > DEPTH) ? DEPTH : int'(cap));
    pool_n = lim + $urandom_range(1, 6);
    if (pool_n > POOL_MAX) pool_n = POOL_MAX;
    // keep about half the old keys so entries from earlier settings still hit
    for (int i = 0; i < POOL_MAX; i++)
      if ($urandom_range(0, 1) == 1) key_pool[i] = pick_word();
    for (int n = 0; n < PHASE_ITEMS; n++) put_get(make_item());
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_req    = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    for (int i = 0; i < POOL_MAX; i++) key_pool[i] = $urandom();
    pool_n = 8;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed part at full capacity: empty miss, extreme keys and values
    write_capacity(5'd16);
    phases++;
    put_get(txn(KIND_GET, 32'h0000_0000, 32'h1234_5678));
    put_get(txn(KIND_PUT, 32'h8000_0000, 32'h7fff_ffff));
    put_get(txn(KIND_PUT, 32'h7fff_ffff, 32'h8000_0000));
    put_get(txn(KIND_PUT, 32'hffff_ffff, 32'hffff_ffff));
    put_get(txn(KIND_PUT, 32'h0000_0000, 32'h0000_0000));
    put_get(txn(KIND_GET, 32'h8000_0000, 32'h0000_0000));
    put_get(txn(KIND_GET, 32'h7fff_ffff, 32'hffff_ffff));
    // a hit that returns all ones must still show hit set
    put_get(txn(KIND_GET, 32'hffff_ffff, 32'h0000_0000));
    put_get(txn(KIND_GET, 32'h0000_0000, 32'h8000_0000));
    put_get(txn(KIND_GET, 32'h0000_0001, 32'h0000_0000));
    // put hit overwrites and refreshes
    put_get(txn(KIND_PUT, 32'h8000_0000, 32'h5a5a_5a5a));
    put_get(txn(KIND_GET, 32'h8000_0000, 32'ha5a5_a5a5));
    put_get(txn(KIND_PUT, 32'h0000_0001, 32'h0000_0001));

    // capacity lowered below the fill count: put misses now evict the oldest
    write_capacity(5'd1);
    phases++;
    put_get(txn(KIND_PUT, 32'h0000_0002, 32'h0000_0022));
    put_get(txn(KIND_GET, 32'h7fff_ffff, 32'h0000_0000));
    put_get(txn(KIND_GET, 32'h0000_0002, 32'h0000_0000));
    put_get(txn(KIND_PUT, 32'h0000_0003, 32'h0000_0033));
    put_get(txn(KIND_GET, 32'h0000_0002, 32'h0000_0000));
    put_get(txn(KIND_GET, 32'h0000_0003, 32'h0000_0000));

    // capacity zero acts as one
    write_capacity(5'd0);
    phases++;
    put_get(txn(KIND_PUT, 32'h0000_0004, 32'h0000_0044));
    put_get(txn(KIND_GET, 32'h0000_0003, 32'h0000_0000));
    put_get(txn(KIND_GET, 32'h0000_0004, 32'h0000_0000));

    // random part, on top of the entries left by the directed part
    run_phase(5'd31);
    run_phase(5'd2);
    run_phase(5'd17);
    run_phase(5'd0);
    run_phase(5'd3);
    run_phase(5'd8);
    run_phase(5'd1);
    run_phase(5'($urandom_range(4, 15)));
    run_phase(5'd15);
    run_phase(5'd5);
    run_phase(5'd16);
    run_phase(5'($urandom_range(0, 31)));

    drain();
    $display("covered %0d transactions across %0d capacity settings (zero, one, 16 and above)",
             sent, phases);
    $display("compared %0d results, %0d of them hits", checked, hits);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
